FILE: design/sli_pkg.sv
package sli_pkg;

  // Table size and the widths that follow from it.
  localparam int CAPACITY = 512;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the channels.
  localparam int OP_W     = 2;
  localparam int GROUP_W  = 4;
  localparam int SLOT_W   = 5;
  localparam int KEY_W    = 8;
  localparam int INDEX_W  = 9;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 9;
  localparam int TOTAL_W  = 10;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_OFFER = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [GROUP_W-1:0] group;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   key;
  } entry_t;

  // Datapath actions, one per microcode step.
  typedef enum logic [3:0] {
    A_FETCH,
    A_INIT,
    A_RDIDX,
    A_SRD,
    A_SCMP,
    A_SHRD,
    A_SHIFT,
    A_INS,
    A_SIMPLE
  } act_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_INSERT,
    C_SEARCHING,
    C_IDX_GT_LO,
    C_SHIFT_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [3:0] {
    STEP_FETCH,
    STEP_DISPATCH,
    STEP_RDISSUE,
    STEP_SLOOP,
    STEP_SCMP,
    STEP_SHPRIME,
    STEP_SHIFT,
    STEP_INS,
    STEP_SIMPLE
  } step_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  // Condition flags reported by the datapath to the sequencer.
  typedef struct packed {
    logic accept;
    logic insert;
    logic searching;
    logic idx_gt_lo;
    logic shift_more;
    logic out_busy;
  } flags_t;

  // The microprogram: action, condition, target when true, target when false.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{act: A_FETCH, cond: C_ACCEPT, tgt_t: STEP_DISPATCH, tgt_f: STEP_FETCH};
    unique case (s)
      STEP_FETCH:    w = '{A_FETCH,  C_ACCEPT,     STEP_DISPATCH, STEP_FETCH};
      STEP_DISPATCH: w = '{A_INIT,   C_INSERT,     STEP_SLOOP,    STEP_RDISSUE};
      STEP_RDISSUE:  w = '{A_RDIDX,  C_ALWAYS,     STEP_SIMPLE,   STEP_SIMPLE};
      STEP_SLOOP:    w = '{A_SRD,    C_SEARCHING,  STEP_SCMP,     STEP_SHPRIME};
      STEP_SCMP:     w = '{A_SCMP,   C_ALWAYS,     STEP_SLOOP,    STEP_SLOOP};
      STEP_SHPRIME:  w = '{A_SHRD,   C_IDX_GT_LO,  STEP_SHIFT,    STEP_INS};
      STEP_SHIFT:    w = '{A_SHIFT,  C_SHIFT_MORE, STEP_SHIFT,    STEP_INS};
      STEP_INS:      w = '{A_INS,    C_OUT_BUSY,   STEP_INS,      STEP_FETCH};
      STEP_SIMPLE:   w = '{A_SIMPLE, C_OUT_BUSY,   STEP_SIMPLE,   STEP_FETCH};
      default:       w = '{A_FETCH,  C_ACCEPT,     STEP_DISPATCH, STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

FILE: design/sli_channels.sv
interface sli_in_if;
  import sli_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [GROUP_W-1:0]   group_id;
  logic [SLOT_W-1:0]    slot_id;
  logic [KEY_W-1:0]     key_count;
  logic [INDEX_W-1:0]   read_index;

  modport source (output valid, operation, group_id, slot_id, key_count, read_index,
                  input ready);
  modport sink (input valid, operation, group_id, slot_id, key_count, read_index,
                output ready);
endinterface

interface sli_out_if;
  import sli_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [POS_W-1:0]     position;
  logic [GROUP_W-1:0]   entry_group;
  logic [SLOT_W-1:0]    entry_slot;
  logic [KEY_W-1:0]     entry_key;
  logic [TOTAL_W-1:0]   entry_total;

  modport source (output valid, status, position, entry_group, entry_slot, entry_key,
                  entry_total, input ready);
  modport sink (input valid, status, position, entry_group, entry_slot, entry_key,
                entry_total, output ready);
endinterface

FILE: design/sli_seq.sv
module sli_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  sli_pkg::flags_t flags,
  output sli_pkg::act_t   act
);
  import sli_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  uword_t uw;
  logic   take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    uw = ucode(step_r);
    unique case (uw.cond)
      C_ALWAYS:     take = 1'b1;
      C_ACCEPT:     take = flags.accept;
      C_INSERT:     take = flags.insert;
      C_SEARCHING:  take = flags.searching;
      C_IDX_GT_LO:  take = flags.idx_gt_lo;
      C_SHIFT_MORE: take = flags.shift_more;
      C_OUT_BUSY:   take = flags.out_busy;
      default:      take = 1'b1;
    endcase
    step_nxt = take ? uw.tgt_t : uw.tgt_f;
    act      = uw.act;
  end

endmodule

FILE: design/sli_dpath.sv
module sli_dpath (
  input  logic             clk,
  input  logic             rst_n,
  input  sli_pkg::act_t    act,
  output sli_pkg::flags_t  flags,
  sli_in_if.sink           in_if,
  sli_out_if.source        out_if
);
  import sli_pkg::*;

  entry_t mem [CAPACITY];

  // Latched item.
  op_t                op_r;
  logic [GROUP_W-1:0] grp_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [KEY_W-1:0]   key_r;
  logic [INDEX_W-1:0] ridx_r;

  // Table count and search / shift pointers.
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] mid;

  entry_t rd_data_r;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  entry_t             ent_r, ent_nxt;
  logic [TOTAL_W-1:0] tot_out_r, tot_out_nxt;

  logic              in_ready;
  logic              out_free;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              rd_ok;

  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign out_free = !out_valid_r || out_if.ready;
  assign rd_ok    = (32'(ridx_r) < 32'(total_r)) && (32'(ridx_r) < CAPACITY);

  assign in_if.ready = in_ready;

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = status_r;
  assign out_if.position    = pos_r;
  assign out_if.entry_group = ent_r.group;
  assign out_if.entry_slot  = ent_r.slot;
  assign out_if.entry_key   = ent_r.key;
  assign out_if.entry_total = tot_out_r;

  always_comb begin
    flags.accept     = in_if.valid && in_ready;
    flags.insert     = (op_r == OP_OFFER) && (key_r != '0) &&
                       (total_r < CNT_W'(CAPACITY));
    flags.searching  = lo_r < hi_r;
    flags.idx_gt_lo  = idx_r > lo_r;
    flags.shift_more = (idx_r - CNT_W'(1)) > lo_r;
    flags.out_busy   = !out_free;
  end

  always_comb begin
    in_ready      = 1'b0;
    total_nxt     = total_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    idx_nxt       = idx_r;
    rd_en         = 1'b0;
    rd_addr       = ADDR_W'(mid);
    wr_en         = 1'b0;
    wr_addr       = ADDR_W'(idx_r);
    wr_data       = rd_data_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    ent_nxt       = ent_r;
    tot_out_nxt   = tot_out_r;
    unique case (act)
      A_FETCH: begin
        in_ready = 1'b1;
      end
      A_INIT: begin
        lo_nxt  = '0;
        hi_nxt  = total_r;
        idx_nxt = total_r;
      end
      A_RDIDX: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(ridx_r);
      end
      A_SRD: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(mid);
      end
      A_SCMP: begin
        // Larger keys go first; equal keys keep arrival order.
        if (key_r > rd_data_r.key) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + CNT_W'(1);
        end
      end
      A_SHRD: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(idx_r - CNT_W'(1));
      end
      A_SHIFT: begin
        // Write the entry read last cycle one place down, fetch the next one up.
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(idx_r);
        wr_data = rd_data_r;
        idx_nxt = idx_r - CNT_W'(1);
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(idx_r - CNT_W'(2));
      end
      A_INS: begin
        if (out_free) begin
          wr_en         = 1'b1;
          wr_addr       = ADDR_W'(lo_r);
          wr_data       = '{group: grp_r, slot: slot_r, key: key_r};
          total_nxt     = total_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          status_nxt    = ST_DONE;
          pos_nxt       = POS_W'(lo_r);
          ent_nxt       = '{group: grp_r, slot: slot_r, key: key_r};
          tot_out_nxt   = TOTAL_W'(total_r + CNT_W'(1));
        end
      end
      A_SIMPLE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_DONE;
          pos_nxt       = '0;
          ent_nxt       = '0;
          tot_out_nxt   = TOTAL_W'(total_r);
          unique case (op_r)
            OP_CLEAR: begin
              total_nxt   = '0;
              tot_out_nxt = '0;
            end
            OP_OFFER: begin
              // Only a zero key or a full table ends up here.
              status_nxt = (key_r == '0) ? ST_SKIPPED : ST_FULL;
            end
            OP_READ: begin
              pos_nxt = ridx_r;
              if (rd_ok) begin
                ent_nxt = rd_data_r;
              end else begin
                status_nxt = ST_RANGE;
              end
            end
            OP_NONE: begin
              status_nxt = ST_DONE;
            end
            default: begin
              status_nxt = ST_DONE;
            end
          endcase
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_ready) begin
      op_r   <= op_t'(in_if.operation);
      grp_r  <= in_if.group_id;
      slot_r <= in_if.slot_id;
      key_r  <= in_if.key_count;
      ridx_r <= in_if.read_index;
    end
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    idx_r     <= idx_nxt;
    status_r  <= status_nxt;
    pos_r     <= pos_nxt;
    ent_r     <= ent_nxt;
    tot_out_r <= tot_out_nxt;
  end

endmodule

FILE: design/sorted_list_binary_insert_unit.sv
// Channel | Direction | Handshake           | Payload
// in_if   | input     | valid / ready       | operation, group_id, slot_id, key_count,
//         |           |                     | read_index
// out_if  | output    | valid / ready       | status, position, entry_group, entry_slot,
//         |           |                     | entry_key, entry_total
//
// One item is handled at a time. An offer first runs a binary search of k probes, where k
// is at most about log2 of the count plus one, then moves m entries down one place each;
// the shift loop does one memory write and one read per cycle. Clear, read, unused
// operation codes and dropped offers skip the search and the shift. Reset empties
// the table at once; the entry memory itself is not cleared.
// A result waits in the output register while the next item is accepted and worked
// on; only its final step holds until that register is free.
module sorted_list_binary_insert_unit (
  input logic       clk,
  input logic       rst_n,
  sli_in_if.sink    in_if,
  sli_out_if.source out_if
);
  import sli_pkg::*;

  // The sequencer steps through the microprogram held in the package. Each control
  // word names one datapath action, a jump condition and two targets.
  act_t   act;
  flags_t flags;

  sli_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (act)
  );

  // The datapath holds the entry memory, the count, the search bounds and the
  // output register, and reports the conditions the program branches on.
  sli_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .act    (act),
    .flags  (flags),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

FILE: verif/sli_checker.sv
`timescale 1ns / 1ps

module sli_checker (
  input  logic clk,
  input  logic rst_n,
  sli_in_if    in_if,
  sli_out_if   out_if,
  output int   errors,
  output int   pending
);
  import sli_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [GROUP_W-1:0] group;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   key;
    logic [TOTAL_W-1:0] total;
  } outcome_t;

  // Shadow copy of the sorted table, largest key first.
  entry_t   ranked [CAPACITY];
  int       ranked_count;
  outcome_t expected_outcomes [$];

  initial begin
    errors = 0;
    pending = 0;
    ranked_count = 0;
  end

  // Applies one accepted item to the shadow table and queues its outcome.
  task automatic place_item(input op_t op, input logic [GROUP_W-1:0] grp,
                            input logic [SLOT_W-1:0] slt, input logic [KEY_W-1:0] key,
                            input logic [INDEX_W-1:0] idx);
    outcome_t o;
    int lo, hi, mid;
    o = '0;
    case (op)
      OP_CLEAR: begin
        ranked_count = 0;
      end
      OP_OFFER: begin
        if (key == '0) begin
          o.status = ST_SKIPPED;
        end else if (ranked_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          // Land just after the last entry whose key is not smaller.
          lo = 0;
          hi = ranked_count;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key > ranked[mid].key) hi = mid;
            else lo = mid + 1;
          end
          for (int i = ranked_count; i > lo; i--) ranked[i] = ranked[i-1];
          ranked[lo] = '{group: grp, slot: slt, key: key};
          ranked_count++;
          o.status   = ST_DONE;
          o.position = lo[POS_W-1:0];
          o.group    = grp;
          o.slot     = slt;
          o.key      = key;
        end
      end
      OP_READ: begin
        o.position = idx;
        if (idx >= ranked_count) begin
          o.status = ST_RANGE;
        end else begin
          o.status = ST_DONE;
          o.group  = ranked[idx].group;
          o.slot   = ranked[idx].slot;
          o.key    = ranked[idx].key;
        end
      end
      default: begin
      end
    endcase
    o.total = ranked_count[TOTAL_W-1:0];
    expected_outcomes.push_back(o);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      expected_outcomes.delete();
      ranked_count = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        place_item(op_t'(in_if.operation), in_if.group_id, in_if.slot_id,
                   in_if.key_count, in_if.read_index);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_outcomes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual status %0d position %0d",
                   $time, out_if.status, out_if.position);
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", want.status, out_if.status);
          check_field("position", want.position, out_if.position);
          check_field("entry_group", want.group, out_if.entry_group);
          check_field("entry_slot", want.slot, out_if.entry_slot);
          check_field("entry_key", want.key, out_if.entry_key);
          check_field("entry_total", want.total, out_if.entry_total);
        end
      end
    end
    pending <= expected_outcomes.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the sorted insertion table. The checker beside the
// block keeps its own copy of the table and compares every result; this module
// only produces items, applies backpressure and reports the outcome.
module testbench;
  import sli_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Local copies of the driven signals, so that every input is known from time zero.
  logic               in_valid = 1'b0;
  op_t                in_op    = OP_CLEAR;
  logic [GROUP_W-1:0] in_group = '0;
  logic [SLOT_W-1:0]  in_slot  = '0;
  logic [KEY_W-1:0]   in_key   = '0;
  logic [INDEX_W-1:0] in_index = '0;
  logic               out_ready = 1'b0;

  // When set, neither side inserts idle cycles.
  logic steady = 1'b0;

  // Entry count as the stimulus sees it; steers read indexes and the length of the fill.
  int filled = 0;

  int fail_count;
  int backlog;

  sli_in_if  in_if ();
  sli_out_if out_if ();

  assign in_if.valid      = in_valid;
  assign in_if.operation  = in_op;
  assign in_if.group_id   = in_group;
  assign in_if.slot_id    = in_slot;
  assign in_if.key_count  = in_key;
  assign in_if.read_index = in_index;
  assign out_if.ready     = out_ready;

  sorted_list_binary_insert_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  sli_checker order_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .errors  (fail_count),
    .pending (backlog)
  );

  always #4 clk = ~clk;

  // The receiver stalls with a probability of about 8 percent, except in steady stretches.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 8);
  end

  // Presents one item, holds it until the block takes it, then maybe idles a little.
  task automatic send_item(input op_t op, input logic [GROUP_W-1:0] grp,
                           input logic [SLOT_W-1:0] slt, input logic [KEY_W-1:0] key,
                           input logic [INDEX_W-1:0] idx);
    in_valid <= 1'b1;
    in_op    <= op;
    in_group <= grp;
    in_slot  <= slt;
    in_key   <= key;
    in_index <= idx;
    do @(posedge clk); while (!in_if.ready);
    case (op)
      OP_CLEAR: filled = 0;
      OP_OFFER: if (key != '0 && filled < CAPACITY) filled++;
      default: ;
    endcase
    if (!steady && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stops offering items until every result that is owed has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  // One random item. Offers dominate; a third of the keys are tiny so that
  // equal keys are common and the arrival order among them gets exercised.
  // Reads mostly hit live entries, the rest land anywhere in the index range.
  task automatic random_item(input int offer_pct, input int key_hi);
    int               roll;
    logic [KEY_W-1:0] key;
    logic [INDEX_W-1:0] idx;
    roll = $urandom_range(99);
    if ($urandom_range(2) == 0) key = KEY_W'($urandom_range(1, 4));
    else key = KEY_W'($urandom_range(1, key_hi));
    if ($urandom_range(29) == 0) key = '0;
    if (filled > 0 && $urandom_range(4) != 0) idx = INDEX_W'($urandom_range(filled - 1));
    else idx = INDEX_W'($urandom_range(511));
    if (roll < offer_pct) begin
      send_item(OP_OFFER, GROUP_W'($urandom_range(14)), SLOT_W'($urandom_range(29)),
                key, idx);
    end else if (roll < offer_pct + (100 - offer_pct) * 3 / 4) begin
      send_item(OP_READ, GROUP_W'($urandom_range(14)), SLOT_W'($urandom_range(29)),
                key, idx);
    end else begin
      send_item(OP_NONE, GROUP_W'($urandom_range(14)), SLOT_W'($urandom_range(29)),
                KEY_W'($urandom_range(255)), INDEX_W'($urandom_range(511)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A read of the empty table is out of range, and a zero key
    // is skipped without touching the table.
    send_item(OP_READ, 4'd0, 5'd0, 8'd0, 9'd0);
    send_item(OP_OFFER, 4'd14, 5'd29, 8'd0, 9'd0);
    // Largest and smallest keys, with the top group and slot values of the stimulus and with zero.
    send_item(OP_OFFER, 4'd14, 5'd29, 8'd255, 9'd511);
    send_item(OP_OFFER, 4'd0, 5'd0, 8'd1, 9'd0);
    // An equal key at the top must land after the older one, likewise at the bottom.
    send_item(OP_OFFER, 4'd7, 5'd16, 8'd255, 9'd0);
    send_item(OP_OFFER, 4'd8, 5'd15, 8'd128, 9'd0);
    send_item(OP_OFFER, 4'd3, 5'd2, 8'd1, 9'd0);
    // The unused operation code changes nothing.
    send_item(OP_NONE, 4'd9, 5'd21, 8'd170, 9'd341);
    // Read every live entry and one past the end, then the highest index.
    for (int i = 0; i < 6; i++) begin
      send_item(OP_READ, GROUP_W'($urandom_range(14)), SLOT_W'($urandom_range(29)),
                KEY_W'($urandom_range(255)), i[INDEX_W-1:0]);
    end
    send_item(OP_READ, 4'd0, 5'd0, 8'd0, 9'd511);
    // Clear with busy payload fields, then confirm the table reads as empty.
    send_item(OP_CLEAR, 4'd5, 5'd10, 8'd85, 9'd170);
    send_item(OP_READ, 4'd0, 5'd0, 8'd0, 9'd0);
    wait_drained();

    // Fill the table to capacity with random records. Once it holds a few
    // hundred entries, the shifts are long; one band of the fill runs with no
    // idling on either side.
    send_item(OP_CLEAR, GROUP_W'($urandom_range(14)), SLOT_W'($urandom_range(29)),
              KEY_W'($urandom_range(255)), INDEX_W'($urandom_range(511)));
    while (filled < CAPACITY) begin
      steady <= (filled >= 200 && filled < 300);
      random_item(90, 255);
    end
    steady <= 1'b0;

    // The table is full: offers are dropped, but a zero key still reports as
    // skipped. Reads cover both ends and the middle of the full table.
    send_item(OP_OFFER, 4'd14, 5'd29, 8'd255, 9'd0);
    send_item(OP_OFFER, 4'd0, 5'd0, 8'd1, 9'd0);
    send_item(OP_OFFER, 4'd1, 5'd1, 8'd0, 9'd0);
    send_item(OP_READ, 4'd0, 5'd0, 8'd0, 9'd0);
    send_item(OP_READ, 4'd0, 5'd0, 8'd0, 9'd511);
    send_item(OP_READ, 4'd0, 5'd0, 8'd0, 9'd256);
    wait_drained();

    // Short rounds on a small table with a narrow key range, each starting
    // from a clear, so that ties and out-of-range reads are frequent.
    repeat (4) begin
      send_item(OP_CLEAR, GROUP_W'($urandom_range(14)), SLOT_W'($urandom_range(29)),
                KEY_W'($urandom_range(255)), INDEX_W'($urandom_range(511)));
      repeat (20) random_item(60, 8);
    end

    wait_drained();
    // Allow time for any stray result to show up.
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #13_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: sim.f
design/sli_pkg.sv
design/sli_channels.sv
design/sli_seq.sv
design/sli_dpath.sv
design/sorted_list_binary_insert_unit.sv
verif/sli_checker.sv
verif/testbench.sv
